@@ hdl/hmi_pkg.sv @@
package hmi_pkg;

  localparam int Buckets = 19;
  localparam int Ways = 4;
  localparam int HashMod = 19;

  localparam int KeyW = 31;
  localparam int CountW = 16;
  localparam int StatusW = 3;
  localparam int ResW = 10;
  localparam int HashW = 5;
  localparam int BucketW = (Buckets > 1) ? $clog2(Buckets) : 1;

  localparam int QueueDepth = 2;
  localparam int QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef enum logic {
    OpPut   = 1'b0,
    OpProbe = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StInserted = 3'd0,
    StUpdated  = 3'd1,
    StFull     = 3'd2,
    StMiss     = 3'd3,
    StHit      = 3'd4
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [KeyW-1:0]    key;
    logic [CountW-1:0]  count;
    logic [BucketW-1:0] bucket;
  } item_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } entry_t;

  // 2^9 == -1 (mod 19): alternating sum of 9-bit digits, folded twice.
  // Result lies in [16, 530] and is congruent to the key mod 19.
  function automatic logic [ResW-1:0] fold_key(logic [KeyW-1:0] key);
    logic [10:0] v;
    logic [ResW-1:0] r;
    v = 11'd532 + {2'b0, key[8:0]} + {2'b0, key[26:18]}
        - {2'b0, key[17:9]} - {7'b0, key[30:27]};
    r = 10'd19 + {1'b0, v[8:0]} - {8'b0, v[10:9]};
    return r;
  endfunction

  // q = floor(r * 27 / 512) equals floor(r / 19) for r < 531 except r == 512,
  // where it is one too high; the negative remainder is then brought back.
  function automatic logic [HashW-1:0] mod19_small(logic [ResW-1:0] r);
    logic [14:0] p;
    logic [4:0] q;
    logic [ResW-1:0] rem;
    p = {5'b0, r} * 15'd27;
    q = p[13:9];
    rem = r - ({5'b0, q} * 10'd19);
    if (rem[ResW-1]) begin
      rem = rem + 10'd19;
    end
    return rem[HashW-1:0];
  endfunction

  function automatic logic [BucketW-1:0] bucket_of(logic [HashW-1:0] h);
    logic [BucketW-1:0] b;
    b = '0;
    for (int i = 0; i < HashMod; i++) begin
      if (h == HashW'(i)) begin
        b = BucketW'(i % Buckets);
      end
    end
    return b;
  endfunction

endpackage

@@ hdl/hmi_if.sv @@
interface hmi_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [hmi_pkg::KeyW-1:0]    key;
  logic [hmi_pkg::CountW-1:0]  count;

  modport source(output valid, output operation, output key, output count, input ready);
  modport sink(input valid, input operation, input key, input count, output ready);
endinterface

interface hmi_out_if;
  logic                         valid;
  logic                         ready;
  logic [hmi_pkg::KeyW-1:0]     result_key;
  logic [hmi_pkg::CountW-1:0]   result_count;
  logic [hmi_pkg::StatusW-1:0]  status;

  modport source(output valid, output result_key, output result_count, output status,
                 input ready);
  modport sink(input valid, input result_key, input result_count, input status,
               output ready);
endinterface

@@ hdl/hmi_front.sv @@
module hmi_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  hmi_in_if.sink         in_i,
  output logic           push_valid_o,
  output hmi_pkg::item_t push_item_o,
  input  logic           push_ready_i
);

  logic                          valid_q;
  hmi_pkg::op_e                  op_q;
  logic [hmi_pkg::KeyW-1:0]      key_q;
  logic [hmi_pkg::CountW-1:0]    count_q;
  logic [hmi_pkg::ResW-1:0]      res_q;
  logic                          in_fire;

  assign in_i.ready = !valid_q || push_ready_i;
  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        valid_q <= 1'b1;
        op_q    <= hmi_pkg::op_e'(in_i.operation);
        key_q   <= in_i.key;
        count_q <= in_i.count;
        res_q   <= hmi_pkg::fold_key(in_i.key);
      end else if (push_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign push_valid_o       = valid_q;
  assign push_item_o.op     = op_q;
  assign push_item_o.key    = key_q;
  assign push_item_o.count  = count_q;
  assign push_item_o.bucket = hmi_pkg::bucket_of(hmi_pkg::mod19_small(res_q));

endmodule

@@ hdl/hmi_fifo.sv @@
module hmi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  hmi_pkg::item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output hmi_pkg::item_t pop_item_o,
  input  logic           pop_ready_i
);

  hmi_pkg::item_t                 buf_q [hmi_pkg::QueueDepth];
  logic [hmi_pkg::QPtrW-1:0]      wr_ptr_q;
  logic [hmi_pkg::QPtrW-1:0]      rd_ptr_q;
  logic [hmi_pkg::QCntW-1:0]      cnt_q;
  logic                           push;
  logic                           pop;

  function automatic logic [hmi_pkg::QPtrW-1:0] next_ptr(logic [hmi_pkg::QPtrW-1:0] p);
    return (p == hmi_pkg::QPtrW'(hmi_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready_o = (cnt_q != hmi_pkg::QCntW'(hmi_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = buf_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hmi_pkg::QCntW'(hmi_pkg::QueueDepth))
    else $error("queue fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

@@ hdl/hmi_back.sv @@
module hmi_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  input  hmi_pkg::item_t pop_item_i,
  output logic           pop_ready_o,
  hmi_out_if.source      out_o
);

  typedef enum logic {
    StIdle,
    StLookup
  } state_e;

  state_e                            state_q;
  hmi_pkg::item_t                    cur_q;
  hmi_pkg::entry_t [hmi_pkg::Ways-1:0] mem_q [hmi_pkg::Buckets];
  hmi_pkg::entry_t [hmi_pkg::Ways-1:0] rd_row_q;
  hmi_pkg::entry_t [hmi_pkg::Ways-1:0] wr_row;
  logic [hmi_pkg::Ways-1:0]          valid_q [hmi_pkg::Buckets];

  logic                              out_valid_q;
  logic [hmi_pkg::KeyW-1:0]          out_key_q;
  logic [hmi_pkg::CountW-1:0]        out_count_q;
  hmi_pkg::status_e                  out_status_q;

  logic                              pop_fire;
  logic [hmi_pkg::Ways-1:0]          row_valid;
  logic [hmi_pkg::Ways-1:0]          hit_vec;
  logic [hmi_pkg::Ways-1:0]          hit_oh;
  logic [hmi_pkg::Ways-1:0]          free_vec;
  logic [hmi_pkg::Ways-1:0]          free_oh;
  logic                              any_hit;
  logic                              any_free;
  logic [hmi_pkg::CountW-1:0]        stored;
  logic [hmi_pkg::CountW-1:0]        res_count;
  hmi_pkg::status_e                  res_status;
  logic                              wr_en;
  logic                              ins_en;

  assign pop_ready_o = (state_q == StIdle) && (!out_valid_q || out_o.ready);
  assign pop_fire    = pop_valid_i && pop_ready_o;

  always_comb begin
    row_valid = valid_q[cur_q.bucket];
    stored    = '0;
    for (int w = 0; w < hmi_pkg::Ways; w++) begin
      hit_vec[w] = row_valid[w] && (rd_row_q[w].key == cur_q.key);
    end
    free_vec = ~row_valid;
    hit_oh   = hit_vec & (~hit_vec + hmi_pkg::Ways'(1));
    free_oh  = free_vec & (~free_vec + hmi_pkg::Ways'(1));
    any_hit  = |hit_vec;
    any_free = |free_vec;
    for (int w = 0; w < hmi_pkg::Ways; w++) begin
      if (hit_oh[w]) begin
        stored = stored | rd_row_q[w].count;
      end
    end

    wr_row    = rd_row_q;
    wr_en     = 1'b0;
    ins_en    = 1'b0;
    res_count = '0;
    if (cur_q.op == hmi_pkg::OpPut) begin
      if (any_hit) begin
        res_status = hmi_pkg::StUpdated;
        wr_en = 1'b1;
        for (int w = 0; w < hmi_pkg::Ways; w++) begin
          if (hit_oh[w]) begin
            wr_row[w].count = cur_q.count;
          end
        end
      end else if (any_free) begin
        res_status = hmi_pkg::StInserted;
        wr_en  = 1'b1;
        ins_en = 1'b1;
        for (int w = 0; w < hmi_pkg::Ways; w++) begin
          if (free_oh[w]) begin
            wr_row[w].key   = cur_q.key;
            wr_row[w].count = cur_q.count;
          end
        end
      end else begin
        res_status = hmi_pkg::StFull;
      end
    end else begin
      if (any_hit) begin
        res_status = hmi_pkg::StHit;
        res_count  = (stored < cur_q.count) ? stored : cur_q.count;
      end else begin
        res_status = hmi_pkg::StMiss;
      end
    end
    if (state_q != StLookup) begin
      wr_en  = 1'b0;
      ins_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      rd_row_q <= mem_q[pop_item_i.bucket];
    end
    if (wr_en) begin
      mem_q[cur_q.bucket] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      valid_q     <= '{default: '0};
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pop_fire) begin
            cur_q   <= pop_item_i;
            state_q <= StLookup;
          end
        end
        StLookup: begin
          out_valid_q  <= 1'b1;
          out_key_q    <= cur_q.key;
          out_count_q  <= res_count;
          out_status_q <= res_status;
          if (ins_en) begin
            valid_q[cur_q.bucket] <= row_valid | free_oh;
          end
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_key   = out_key_q;
  assign out_o.result_count = out_count_q;
  assign out_o.status       = out_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookup) |-> !out_valid_q)
    else $error("lookup finished onto an occupied output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire |=> (state_q == StLookup))
    else $error("popped transaction not looked up");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookup) |=> out_valid_q)
    else $error("lookup produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLookup) |-> $onehot0(hit_vec))
    else $error("key stored twice in one bucket");

endmodule

@@ hdl/hashed_multiset_intersection.sv @@
// Each item passes the front register, queue, lookup state and output register.
// The back end takes no new transaction during a lookup, because of its read-then-write
// of a bucket row in the single-port bucket memory.
// A 2-deep queue between front and back absorbs stalls on either side.
// Reset (rst_ni, async, active low) clears all entry valid bits at once; no clearing pass.
module hashed_multiset_intersection (
  input  logic      clk_i,
  input  logic      rst_ni,
  hmi_in_if.sink    in_i,
  hmi_out_if.source out_o
);

  logic           push_valid;
  logic           push_ready;
  hmi_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  hmi_pkg::item_t pop_item;

  hmi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  hmi_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  hmi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
